@@ hw/rtl/mfft_pkg.sv @@
// Package for the matrix fill, flip and transpose engine.
// Holds field widths, command codes, state and walk-direction types.
// No dependencies; used by the top level and the checker.
package mfft_pkg;

  localparam int CNT_W       = 6;
  localparam int IDX_W       = 5;
  localparam int KIND_W      = 3;
  localparam int DATA_W      = 32;
  localparam int NUM_W       = 12;
  localparam int IN_TDATA_W  = 48;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;

  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd4;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE,
    KIND_READ,
    KIND_FILL_ROW,
    KIND_FILL_SPIRAL,
    KIND_FLIP_ROWS,
    KIND_FLIP_COLS,
    KIND_TREAD
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL_ROW,
    ST_FILL_SPIRAL,
    ST_FLIP_RD,
    ST_FLIP_WA,
    ST_FLIP_WB
  } state_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

endpackage

@@ hw/rtl/mfft_ram.sv @@
// Generic synchronous RAM: one write port, two read ports.
// Read data is registered and holds while its read enable is low. No dependencies.
module mfft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/matrix_fill_flip_transpose_engine_unit.sv @@
// Matrix fill, flip and anti-transpose engine, top level.
// Depends on mfft_pkg and mfft_ram.
//
// After reset all MAX_ROWS*MAX_COLS store entries are swept to zero, one per cycle;
// in_tready stays low during the sweep. Element accesses stream at one per cycle unless the
// output stalls; a read result passes the store's registered read port and the output register
// before it shows on out_tvalid. A row-major or spiral fill writes one element per cycle. A flip
// reads a pair, then writes its two elements in turn through the single write port of the store,
// reading the next pair with the second write. Requests are held off while a fill or flip runs.
module matrix_fill_flip_transpose_engine_unit #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [4:0] row, [9:5] col, [41:10] value, [47:42] zero
  input  logic [mfft_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] kind
  input  logic [mfft_pkg::KIND_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] read_value
  output logic [mfft_pkg::DATA_W-1:0]       out_tdata,
  // [0] out_of_range
  output logic                              out_tuser,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mfft_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [mfft_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [mfft_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);

  import mfft_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c);
    addr_of = AW'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  function automatic logic [AW-1:0] flip_addr(input logic [CNT_W-1:0] o,
                                              input logic [CNT_W-1:0] i,
                                              input logic             cols,
                                              input logic             second,
                                              input logic [CNT_W-1:0] rows_n,
                                              input logic [CNT_W-1:0] cols_n);
    logic [CNT_W-1:0] mi;
    mi = second ? CNT_W'((cols ? cols_n : rows_n) - CNT_W'(1) - i) : i;
    flip_addr = cols ? addr_of(o, mi) : addr_of(mi, o);
  endfunction

  logic [CNT_W-1:0] row_count_r, col_count_r;
  logic [CNT_W-1:0] nr, nc;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CNT_W-1:0] r_r, r_nxt, c_r, c_nxt;
  logic [CNT_W-1:0] top_r, top_nxt, bot_r, bot_nxt, left_r, left_nxt, right_r, right_nxt;
  dir_t             dir_r, dir_nxt;
  logic [NUM_W-1:0] num_r, num_nxt, total_r, total_nxt;
  logic [CNT_W-1:0] outer_r, outer_nxt, inner_r, inner_nxt;
  logic [CNT_W-1:0] outer_lim_r, outer_lim_nxt, half_r, half_nxt;
  logic             flip_cols_r, flip_cols_nxt;
  logic [CNT_W-1:0] outer_step, inner_step;
  logic             flip_last;

  logic             pend_r, pend_nxt, pend_oor_r, pend_oor_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic             out_oor_r, out_oor_nxt;
  logic             out_load;

  logic             we, re_a, re_b;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [DATA_W-1:0] wdata, rdata_a, rdata_b;

  logic             in_acc, cfg_wr;
  kind_t            in_kind;
  logic [CNT_W-1:0] in_row, in_col;
  logic [DATA_W-1:0] in_value;
  logic             rd_in_range, tr_in_range;

  assign nr = (32'(row_count_r) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : row_count_r;
  assign nc = (32'(col_count_r) > MAX_COLS) ? CNT_W'(MAX_COLS) : col_count_r;

  assign in_kind  = kind_t'(in_tuser);
  assign in_row   = {1'b0, in_tdata[4:0]};
  assign in_col   = {1'b0, in_tdata[9:5]};
  assign in_value = in_tdata[41:10];

  assign rd_in_range = (in_row < nr) && (in_col < nc);
  assign tr_in_range = (in_row < nc) && (in_col < nr);

  assign in_tready = (state_r == ST_IDLE) && !(pend_r && out_valid_r && !out_tready);
  assign in_acc    = in_tvalid && in_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COL_COUNT) ? CFG_DW'(col_count_r)
                                                      : CFG_DW'(row_count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= COUNT_RESET;
      col_count_r <= COUNT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_ROW_COUNT) begin
        row_count_r <= cfg_pwdata[CNT_W-1:0];
      end else begin
        col_count_r <= cfg_pwdata[CNT_W-1:0];
      end
    end
  end

  mfft_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re_a    (re_a),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // advance the flip pair, inner index fastest
  always_comb begin
    if (inner_r == CNT_W'(half_r - CNT_W'(1))) begin
      inner_step = '0;
      outer_step = CNT_W'(outer_r + CNT_W'(1));
    end else begin
      inner_step = CNT_W'(inner_r + CNT_W'(1));
      outer_step = outer_r;
    end
    flip_last = (inner_r == CNT_W'(half_r - CNT_W'(1))) &&
                (outer_r == CNT_W'(outer_lim_r - CNT_W'(1)));
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    dir_nxt       = dir_r;
    num_nxt       = num_r;
    total_nxt     = total_r;
    outer_nxt     = outer_r;
    inner_nxt     = inner_r;
    outer_lim_nxt = outer_lim_r;
    half_nxt      = half_r;
    flip_cols_nxt = flip_cols_r;
    pend_oor_nxt  = pend_oor_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    re_a          = 1'b0;
    raddr_a       = '0;
    re_b          = 1'b0;
    raddr_b       = '0;
    pend_nxt      = pend_r && !out_load;

    case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = AW'(clr_r + AW'(1));
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_WRITE: begin
              if (rd_in_range) begin
                we    = 1'b1;
                waddr = addr_of(in_row, in_col);
                wdata = in_value;
              end
            end
            KIND_READ: begin
              pend_nxt     = 1'b1;
              pend_oor_nxt = !rd_in_range;
              re_a         = rd_in_range;
              raddr_a      = addr_of(in_row, in_col);
            end
            KIND_TREAD: begin
              pend_nxt     = 1'b1;
              pend_oor_nxt = !tr_in_range;
              re_a         = tr_in_range;
              raddr_a      = addr_of(CNT_W'(nr - CNT_W'(1) - in_col),
                                     CNT_W'(nc - CNT_W'(1) - in_row));
            end
            KIND_FILL_ROW: begin
              r_nxt   = '0;
              c_nxt   = '0;
              num_nxt = NUM_W'(1);
              if (nr != '0 && nc != '0) begin
                state_nxt = ST_FILL_ROW;
              end
            end
            KIND_FILL_SPIRAL: begin
              r_nxt     = '0;
              c_nxt     = '0;
              top_nxt   = '0;
              left_nxt  = '0;
              bot_nxt   = CNT_W'(nr - CNT_W'(1));
              right_nxt = CNT_W'(nc - CNT_W'(1));
              dir_nxt   = DIR_RIGHT;
              num_nxt   = NUM_W'(1);
              total_nxt = NUM_W'(NUM_W'(nr) * NUM_W'(nc));
              if (nr != '0 && nc != '0) begin
                state_nxt = ST_FILL_SPIRAL;
              end
            end
            KIND_FLIP_ROWS: begin
              outer_nxt     = '0;
              inner_nxt     = '0;
              outer_lim_nxt = nc;
              half_nxt      = nr >> 1;
              flip_cols_nxt = 1'b0;
              if ((nr >> 1) != '0 && nc != '0) begin
                state_nxt = ST_FLIP_RD;
              end
            end
            KIND_FLIP_COLS: begin
              outer_nxt     = '0;
              inner_nxt     = '0;
              outer_lim_nxt = nr;
              half_nxt      = nc >> 1;
              flip_cols_nxt = 1'b1;
              if ((nc >> 1) != '0 && nr != '0) begin
                state_nxt = ST_FLIP_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL_ROW: begin
        we      = 1'b1;
        waddr   = addr_of(r_r, c_r);
        wdata   = DATA_W'(num_r);
        num_nxt = NUM_W'(num_r + NUM_W'(1));
        if (c_r == CNT_W'(nc - CNT_W'(1))) begin
          c_nxt = '0;
          r_nxt = CNT_W'(r_r + CNT_W'(1));
          if (r_r == CNT_W'(nr - CNT_W'(1))) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          c_nxt = CNT_W'(c_r + CNT_W'(1));
        end
      end
      ST_FILL_SPIRAL: begin
        we      = 1'b1;
        waddr   = addr_of(r_r, c_r);
        wdata   = DATA_W'(num_r);
        num_nxt = NUM_W'(num_r + NUM_W'(1));
        if (num_r == total_r) begin
          state_nxt = ST_IDLE;
        end
        case (dir_r)
          DIR_RIGHT: begin
            if (c_r == right_r) begin
              top_nxt = CNT_W'(top_r + CNT_W'(1));
              r_nxt   = CNT_W'(r_r + CNT_W'(1));
              dir_nxt = DIR_DOWN;
            end else begin
              c_nxt = CNT_W'(c_r + CNT_W'(1));
            end
          end
          DIR_DOWN: begin
            if (r_r == bot_r) begin
              right_nxt = CNT_W'(right_r - CNT_W'(1));
              c_nxt     = CNT_W'(c_r - CNT_W'(1));
              dir_nxt   = DIR_LEFT;
            end else begin
              r_nxt = CNT_W'(r_r + CNT_W'(1));
            end
          end
          DIR_LEFT: begin
            if (c_r == left_r) begin
              bot_nxt = CNT_W'(bot_r - CNT_W'(1));
              r_nxt   = CNT_W'(r_r - CNT_W'(1));
              dir_nxt = DIR_UP;
            end else begin
              c_nxt = CNT_W'(c_r - CNT_W'(1));
            end
          end
          DIR_UP: begin
            if (r_r == top_r) begin
              left_nxt = CNT_W'(left_r + CNT_W'(1));
              c_nxt    = CNT_W'(c_r + CNT_W'(1));
              dir_nxt  = DIR_RIGHT;
            end else begin
              r_nxt = CNT_W'(r_r - CNT_W'(1));
            end
          end
          default: begin
          end
        endcase
      end
      ST_FLIP_RD: begin
        re_a      = 1'b1;
        re_b      = 1'b1;
        raddr_a   = flip_addr(outer_r, inner_r, flip_cols_r, 1'b0, nr, nc);
        raddr_b   = flip_addr(outer_r, inner_r, flip_cols_r, 1'b1, nr, nc);
        state_nxt = ST_FLIP_WA;
      end
      ST_FLIP_WA: begin
        we        = 1'b1;
        waddr     = flip_addr(outer_r, inner_r, flip_cols_r, 1'b0, nr, nc);
        wdata     = rdata_b;
        state_nxt = ST_FLIP_WB;
      end
      ST_FLIP_WB: begin
        we    = 1'b1;
        waddr = flip_addr(outer_r, inner_r, flip_cols_r, 1'b1, nr, nc);
        wdata = rdata_a;
        if (flip_last) begin
          state_nxt = ST_IDLE;
        end else begin
          inner_nxt = inner_step;
          outer_nxt = outer_step;
          re_a      = 1'b1;
          re_b      = 1'b1;
          raddr_a   = flip_addr(outer_step, inner_step, flip_cols_r, 1'b0, nr, nc);
          raddr_b   = flip_addr(outer_step, inner_step, flip_cols_r, 1'b1, nr, nc);
          state_nxt = ST_FLIP_WA;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_load      = pend_r && (!out_valid_r || out_tready);
    out_valid_nxt = out_load || (out_valid_r && !out_tready);
    out_data_nxt  = out_data_r;
    out_oor_nxt   = out_oor_r;
    if (out_load) begin
      out_data_nxt = pend_oor_r ? '0 : rdata_a;
      out_oor_nxt  = pend_oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r         <= r_nxt;
    c_r         <= c_nxt;
    top_r       <= top_nxt;
    bot_r       <= bot_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    dir_r       <= dir_nxt;
    num_r       <= num_nxt;
    total_r     <= total_nxt;
    outer_r     <= outer_nxt;
    inner_r     <= inner_nxt;
    outer_lim_r <= outer_lim_nxt;
    half_r      <= half_nxt;
    flip_cols_r <= flip_cols_nxt;
    pend_oor_r  <= pend_oor_nxt;
    out_data_r  <= out_data_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_oor_r;

endmodule

@@ hw/rtl/mfft_checker.sv @@
// Port-level checker for the matrix fill, flip and transpose engine, bound to the top level.
// Depends on mfft_pkg for the request kind codes.
module mfft_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [mfft_pkg::KIND_W-1:0]     in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mfft_pkg::DATA_W-1:0]     out_tdata,
  input logic                            out_tuser
);

  import mfft_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("in_tready or out_tvalid high right after reset");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out-of-range result carries nonzero data");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid &&
    (in_tuser == KIND_READ || in_tuser == KIND_TREAD) |=> ##1 out_tvalid)
    else $error("read request produced no result two cycles later");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result dropped or changed");

endmodule

bind matrix_fill_flip_transpose_engine_unit mfft_checker u_mfft_checker (.*);
